[design/pgr_pkg.sv]
package pgr_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int CH_W         = 3;
    localparam int PWM_W        = 16;
    localparam int HITS_W       = 8;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_IDX_W    = 2;

    localparam logic [HITS_W-1:0]       HITS_MAX      = 8'd255;
    localparam logic [NUM_CHANNELS-1:0] MASK_RESET    = '0;
    localparam logic [PWM_W-1:0]        BAND_RESET    = 16'd80;
    localparam logic [HITS_W-1:0]       CONFIRM_RESET = 8'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MASK    = 2'd0,
        CFG_BAND    = 2'd1,
        CFG_CONFIRM = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [PWM_W-1:0]  stable;
        logic [PWM_W-1:0]  cand;
        logic [HITS_W-1:0] hits;
    } t_chan_state;

    typedef struct packed {
        logic              enabled;
        logic              ch_ready;
        logic              sample_valid;
        logic [PWM_W-1:0]  pwm_value;
        t_chan_state       st;
        logic [PWM_W-1:0]  near_band;
        logic [HITS_W-1:0] confirm;
    } t_upd_req;

    typedef struct packed {
        logic             wr_en;
        logic             set_ready;
        t_chan_state      st;
        logic [PWM_W-1:0] pwm_out;
        logic             held;
    } t_upd_rsp;

endpackage

[design/pgr_in_if.sv]
interface pgr_in_if import pgr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CH_W-1:0]  channel;
    logic [PWM_W-1:0] pwm_value;
    logic             sample_valid;

    modport source (output valid, channel, pwm_value, sample_valid, input ready);
    modport sink   (input valid, channel, pwm_value, sample_valid, output ready);
endinterface

[design/pgr_out_if.sv]
interface pgr_out_if import pgr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PWM_W-1:0] pwm_out;
    logic             held;

    modport source (output valid, pwm_out, held, input ready);
    modport sink   (input valid, pwm_out, held, output ready);
endinterface

[design/pgr_update.sv]
module pgr_update import pgr_pkg::*; (
    input  t_upd_req i_req,
    output t_upd_rsp o_rsp
);

    logic [PWM_W-1:0]  diff_stable;
    logic [PWM_W-1:0]  diff_cand;
    logic              near_stable;
    logic              near_cand;
    logic [HITS_W-1:0] hits_inc;

    assign diff_stable = (i_req.pwm_value >= i_req.st.stable) ?
                         i_req.pwm_value - i_req.st.stable :
                         i_req.st.stable - i_req.pwm_value;
    assign diff_cand   = (i_req.pwm_value >= i_req.st.cand) ?
                         i_req.pwm_value - i_req.st.cand :
                         i_req.st.cand - i_req.pwm_value;
    assign near_stable = diff_stable <= i_req.near_band;
    assign near_cand   = diff_cand <= i_req.near_band;

    always_comb begin
        o_rsp           = '0;
        o_rsp.st        = i_req.st;
        o_rsp.pwm_out   = i_req.pwm_value;
        o_rsp.held      = 1'b0;
        hits_inc        = '0;
        if (i_req.enabled) begin
            priority if (!i_req.sample_valid) begin
                if (i_req.ch_ready) begin
                    o_rsp.pwm_out = i_req.st.stable;
                    o_rsp.held    = 1'b1;
                end
            end else if (!i_req.ch_ready || near_stable) begin
                o_rsp.wr_en     = 1'b1;
                o_rsp.set_ready = 1'b1;
                o_rsp.st.stable = i_req.pwm_value;
                o_rsp.st.cand   = i_req.pwm_value;
                o_rsp.st.hits   = '0;
            end else begin
                o_rsp.wr_en = 1'b1;
                if (near_cand) begin
                    hits_inc = (i_req.st.hits == HITS_MAX) ? HITS_MAX :
                               i_req.st.hits + HITS_W'(1);
                end else begin
                    hits_inc      = HITS_W'(1);
                    o_rsp.st.cand = i_req.pwm_value;
                end
                if (hits_inc >= i_req.confirm) begin
                    o_rsp.st.stable = i_req.pwm_value;
                    o_rsp.st.hits   = '0;
                end else begin
                    o_rsp.st.hits = hits_inc;
                    o_rsp.pwm_out = i_req.st.stable;
                    o_rsp.held    = 1'b1;
                end
            end
        end
    end

endmodule

[design/pwm_glitch_rejector_top.sv]
// channel  dir  payload                              accepted when
// i_smp    in   channel, pwm_value, sample_valid     valid && ready
// o_res    out  pwm_out, held                        valid && ready
// i_cfg    in   i_cfg_idx, i_cfg_data                i_cfg_we
//
// one item per cycle sustained unless o_res stalls; each item passes the stage then the output register
// channel state lives in an 8-entry memory read at accept, written back when the item leaves the update stage
// a write-back to the channel being read is forwarded into the read register
// while the result waits one more item enters the update stage, then input stalls
// synchronous active-low reset clears control and the per-channel ready bits, loads config defaults
module pwm_glitch_rejector_top import pgr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pgr_in_if.sink                i_smp,
    pgr_out_if.source             o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_chan_state r_mem [NUM_CHANNELS];
    t_chan_state r_rd_data;

    logic [NUM_CHANNELS-1:0] r_mask;
    logic [PWM_W-1:0]        r_band;
    logic [HITS_W-1:0]       r_confirm;
    logic [NUM_CHANNELS-1:0] r_ch_ready;

    logic             r_s1_valid;
    logic [CH_W-1:0]  r_s1_ch;
    logic [PWM_W-1:0] r_s1_pwm;
    logic             r_s1_sv;

    logic             r_out_valid;
    logic             n_out_valid;
    logic [PWM_W-1:0] r_out_pwm;
    logic             r_out_held;

    logic     s1_advance;
    logic     in_acc;
    logic     upd_we;
    t_upd_req req;
    t_upd_rsp rsp;

    assign s1_advance  = r_s1_valid && (!r_out_valid || o_res.ready);
    assign i_smp.ready = !r_s1_valid || s1_advance;
    assign in_acc      = i_smp.valid && i_smp.ready;
    assign upd_we      = s1_advance && rsp.wr_en;

    always_comb begin
        req.enabled      = r_mask[r_s1_ch];
        req.ch_ready     = r_ch_ready[r_s1_ch];
        req.sample_valid = r_s1_sv;
        req.pwm_value    = r_s1_pwm;
        req.st           = r_rd_data;
        req.near_band    = r_band;
        req.confirm      = r_confirm;
    end

    pgr_update u_update (
        .i_req (req),
        .o_rsp (rsp)
    );

    always_ff @(posedge i_clk) begin
        if (upd_we) begin
            r_mem[r_s1_ch] <= rsp.st;
        end
        if (in_acc) begin
            r_rd_data <= (upd_we && r_s1_ch == i_smp.channel) ? rsp.st
                                                               : r_mem[i_smp.channel];
            r_s1_ch   <= i_smp.channel;
            r_s1_pwm  <= i_smp.pwm_value;
            r_s1_sv   <= i_smp.sample_valid;
        end
        if (s1_advance) begin
            r_out_pwm  <= rsp.pwm_out;
            r_out_held <= rsp.held;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        priority if (s1_advance) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_ch_ready  <= '0;
            r_mask      <= MASK_RESET;
            r_band      <= BAND_RESET;
            r_confirm   <= CONFIRM_RESET;
        end else begin
            r_out_valid <= n_out_valid;
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_advance) begin
                r_s1_valid <= 1'b0;
            end
            if (upd_we && rsp.set_ready) begin
                r_ch_ready[r_s1_ch] <= 1'b1;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MASK:    r_mask    <= i_cfg_data[NUM_CHANNELS-1:0];
                    CFG_BAND:    r_band    <= i_cfg_data[PWM_W-1:0];
                    CFG_CONFIRM: r_confirm <= i_cfg_data[HITS_W-1:0];
                    default:     ;
                endcase
            end
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.pwm_out = r_out_pwm;
    assign o_res.held    = r_out_held;

    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_advance |=> r_out_valid)
        else $error("stage result did not reach the output register");

    a_stall_holds_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_advance |=> r_s1_valid && $stable(r_s1_ch) && $stable(r_s1_pwm))
        else $error("stalled item lost from the update stage");

    a_ready_bits_on_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ch_ready != $past(r_ch_ready) |-> $past(upd_we) && $past(i_rst_n))
        else $error("channel ready bit changed without a state write");

endmodule
